// ===== hdl/mexp_pkg.sv =====
// Shared declarations for the modular exponentiation block.
// Holds the default operand width and the controller/datapath command and status types.
// Depends on nothing; every other file of the block imports it.
package mexp_pkg;

    localparam int DefaultWidth = 64;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture a new transaction and start the base reduction
        logic step;        // advance both modular multipliers by one multiplier bit
        logic take_red;    // commit the reduced base
        logic start_iter;  // start multiply and square for one exponent bit
        logic update;      // commit result, squared base and shifted exponent
        logic finish;      // copy the result into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic e_zero;      // remaining exponent is zero
    } t_dp_status;

endpackage

// ===== hdl/mexp_mulmod.sv =====
// Bit-serial modular multiplier: acc = (acc * 2 + bit * addend) mod m, one bit per cycle while i_step is high.
// A modulus of zero makes the arithmetic wrap at 2^WIDTH.
// Depends on mexp_pkg for the default width.
module mexp_mulmod #(
    parameter int WIDTH = mexp_pkg::DefaultWidth
) (
    input  logic             i_clk,
    input  logic             i_load,
    input  logic             i_step,
    input  logic [WIDTH-1:0] i_addend,
    input  logic [WIDTH-1:0] i_mult,
    input  logic [WIDTH-1:0] i_modulus,
    output logic [WIDTH-1:0] o_acc
);
    import mexp_pkg::*;

    localparam int SumWidth = WIDTH + 3;

    logic [WIDTH-1:0]    r_acc;
    logic [WIDTH-1:0]    r_addend;
    logic [WIDTH-1:0]    r_mult;
    logic [WIDTH-1:0]    n_acc;
    logic [SumWidth-1:0] w_sum;
    logic [SumWidth-1:0] w_d1;
    logic [SumWidth-1:0] w_d2;

    // The sum stays below three times the modulus, so at most two subtractions are needed.
    // Both are formed in parallel and the sign bits pick the answer.
    always_comb begin
        w_sum = {2'b00, r_acc, 1'b0}
              + {3'b000, r_addend & {WIDTH{r_mult[WIDTH-1]}}};
        w_d1  = w_sum - {3'b000, i_modulus};
        w_d2  = w_sum - {2'b00, i_modulus, 1'b0};
        if (i_modulus == '0) begin
            n_acc = w_sum[WIDTH-1:0];
        end else if (!w_d2[SumWidth-1]) begin
            n_acc = w_d2[WIDTH-1:0];
        end else if (!w_d1[SumWidth-1]) begin
            n_acc = w_d1[WIDTH-1:0];
        end else begin
            n_acc = w_sum[WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_acc    <= '0;
            r_addend <= i_addend;
            r_mult   <= i_mult;
        end else if (i_step) begin
            r_acc    <= n_acc;
            r_mult   <= {r_mult[WIDTH-2:0], 1'b0};
        end
    end

    assign o_acc = r_acc;

endmodule

// ===== hdl/mexp_datapath.sv =====
// Datapath of the modular exponentiation block: running result, base, exponent,
// two bit-serial modular multipliers and the output register.
// Depends on mexp_pkg and mexp_mulmod.
module mexp_datapath #(
    parameter int WIDTH = mexp_pkg::DefaultWidth
) (
    input  logic                   i_clk,
    input  mexp_pkg::t_dp_cmd      i_cmd,
    output mexp_pkg::t_dp_status   o_status,
    input  logic [WIDTH-1:0]       i_base_value,
    input  logic [WIDTH-1:0]       i_exponent,
    input  logic [WIDTH-1:0]       i_modulus,
    output logic [WIDTH-1:0]       o_power_result
);
    import mexp_pkg::*;

    logic [WIDTH-1:0] r_r;
    logic [WIDTH-1:0] r_b;
    logic [WIDTH-1:0] r_e;
    logic [WIDTH-1:0] r_out;
    logic [WIDTH-1:0] w_acc_r;
    logic [WIDTH-1:0] w_acc_b;
    logic [WIDTH-1:0] w_b_addend;
    logic [WIDTH-1:0] w_b_mult;

    // The result unit forms r * b while the base unit forms b * b.
    mexp_mulmod #(.WIDTH(WIDTH)) u_mul_r (
        .i_clk     (i_clk),
        .i_load    (i_cmd.start_iter),
        .i_step    (i_cmd.step),
        .i_addend  (r_b),
        .i_mult    (r_r),
        .i_modulus (i_modulus),
        .o_acc     (w_acc_r)
    );

    // On a new transaction the base unit reduces the base as 1 * base mod m.
    assign w_b_addend = i_cmd.load ? WIDTH'(1) : r_b;
    assign w_b_mult   = i_cmd.load ? i_base_value : r_b;

    mexp_mulmod #(.WIDTH(WIDTH)) u_mul_b (
        .i_clk     (i_clk),
        .i_load    (i_cmd.load | i_cmd.start_iter),
        .i_step    (i_cmd.step),
        .i_addend  (w_b_addend),
        .i_mult    (w_b_mult),
        .i_modulus (i_modulus),
        .o_acc     (w_acc_b)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_r <= WIDTH'(1);
            r_e <= i_exponent;
        end
        if (i_cmd.take_red) begin
            r_b <= w_acc_b;
        end
        if (i_cmd.update) begin
            if (r_e[0]) begin
                r_r <= w_acc_r;
            end
            r_b <= w_acc_b;
            r_e <= {1'b0, r_e[WIDTH-1:1]};
        end
        if (i_cmd.finish) begin
            r_out <= r_r;
        end
    end

    assign o_status.e_zero = (r_e == '0);
    assign o_power_result  = r_out;

endmodule

// ===== hdl/mexp_ctrl.sv =====
// Controller of the modular exponentiation block: sequences reduction,
// multiply/square iterations and the output handshake.
// Depends on mexp_pkg for the command and status types.
module mexp_ctrl #(
    parameter int WIDTH = mexp_pkg::DefaultWidth
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    output logic                   o_valid,
    input  logic                   i_stall,
    output mexp_pkg::t_dp_cmd      o_cmd,
    input  mexp_pkg::t_dp_status   i_status
);
    import mexp_pkg::*;

    localparam int CntWidth = $clog2(WIDTH);
    localparam logic [CntWidth-1:0] LastStep = CntWidth'(WIDTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_TAKE,
        S_CHECK,
        S_MUL,
        S_UPDATE
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [CntWidth-1:0] r_cnt;
    logic [CntWidth-1:0] n_cnt;
    logic                r_valid;
    logic                n_valid;
    t_dp_cmd             w_cmd;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_valid = r_valid & i_stall;
        w_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    w_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_REDUCE;
                end
            end
            S_REDUCE: begin
                w_cmd.step = 1'b1;
                if (r_cnt == LastStep) begin
                    n_state = S_TAKE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_TAKE: begin
                w_cmd.take_red = 1'b1;
                n_state        = S_CHECK;
            end
            S_CHECK: begin
                if (i_status.e_zero) begin
                    // Wait here until the output register is free.
                    if (!r_valid || !i_stall) begin
                        w_cmd.finish = 1'b1;
                        n_valid      = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else begin
                    w_cmd.start_iter = 1'b1;
                    n_cnt            = '0;
                    n_state          = S_MUL;
                end
            end
            S_MUL: begin
                w_cmd.step = 1'b1;
                if (r_cnt == LastStep) begin
                    n_state = S_UPDATE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_UPDATE: begin
                w_cmd.update = 1'b1;
                n_state      = S_CHECK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    assign o_cmd   = w_cmd;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;

    a_load_starts_reduce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |=> (r_state == S_REDUCE) && (r_cnt == '0))
        else $error("load did not start the base reduction");

    a_mul_runs_full_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) && (r_cnt == LastStep) |=> (r_state == S_UPDATE))
        else $error("multiply phase did not end after the last bit");

    a_finish_needs_zero_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |-> i_status.e_zero)
        else $error("result delivered with exponent bits left");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |-> (!r_valid || !i_stall))
        else $error("pending result overwritten");

endmodule

// ===== hdl/modular_exponentiation.sv =====
// Top level of the modular exponentiation block.
// Holds the modulus register and joins mexp_ctrl with mexp_datapath; uses mexp_pkg.
//
// Computes power_result = base_value ^ exponent mod modulus by right-to-left
// square-and-multiply, one transaction at a time. An accepted transaction first
// reduces the base modulo the modulus, then runs one multiply/square iteration
// for every exponent bit up to the highest set one; the multiply by the base
// and the squaring of the base run side by side in two bit-serial modular
// multipliers that retire one multiplier bit per cycle. If the previous result
// is still waiting in the output register, the new result waits for it to be
// taken. The input stall goes low in the same cycle as the output valid rises,
// while the finished result waits in the output register until its transaction
// completes. An exponent of zero always returns 1, even with a modulus of 1.
// The modulus resets to 1 and should be written only while no transaction is
// in flight; a modulus of zero makes the arithmetic wrap at 2^WIDTH.
module modular_exponentiation #(
    parameter int WIDTH = mexp_pkg::DefaultWidth
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [WIDTH-1:0] i_cfg_wr_data,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [WIDTH-1:0] i_base_value,
    input  logic [WIDTH-1:0] i_exponent,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [WIDTH-1:0] o_power_result
);
    import mexp_pkg::*;

    logic [WIDTH-1:0] r_modulus;
    t_dp_cmd          w_cmd;
    t_dp_status       w_status;

    // The modulus is configuration, so it gets its defined reset value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= WIDTH'(1);
        end else if (i_cfg_wr_en) begin
            r_modulus <= i_cfg_wr_data;
        end
    end

    // The controller only sequences; all arithmetic lives in the datapath.
    mexp_ctrl #(.WIDTH(WIDTH)) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_cmd    (w_cmd),
        .i_status (w_status)
    );

    mexp_datapath #(.WIDTH(WIDTH)) u_datapath (
        .i_clk          (i_clk),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_base_value   (i_base_value),
        .i_exponent     (i_exponent),
        .i_modulus      (r_modulus),
        .o_power_result (o_power_result)
    );

endmodule
